// ===== hdl/field_parity_sync_corrector_core_assert.svh =====
// ---------------------------------------------------------------------------
// Field parity sync corrector: assertion macros
// Concurrent checks on one clock with a synchronous active-low reset.
// Define ASSERT_OFF to compile every check away.
// ---------------------------------------------------------------------------
`ifndef FIELD_PARITY_SYNC_CORRECTOR_CORE_ASSERT_SVH
`define FIELD_PARITY_SYNC_CORRECTOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent
`define FPSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpsc assertion failed");
// Consequent must hold in the cycle after the antecedent
`define FPSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpsc assertion failed");
`else
`define FPSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FPSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/fpsc_pkg.sv =====
// ---------------------------------------------------------------------------
// fpsc_pkg
// Shared widths, constants, codes and controller/datapath interface types
// for the field parity sync corrector.
// ---------------------------------------------------------------------------
`default_nettype none

package fpsc_pkg;

    // Field and register widths
    localparam int TS_W      = 33;   // 90 kHz timestamps
    localparam int CFG_W     = 16;   // configuration data
    localparam int CFG_IDX_W = 1;    // configuration register index
    localparam int PW        = 33;   // frame period
    localparam int SW        = 38;   // signed measurement arithmetic
    localparam int OFF_W     = 40;   // presentation offset
    localparam int RTR_W     = 8;    // retry count
    localparam int STAT_W    = 2;
    localparam int ACT_W     = 2;

    // Shared iterative divider
    localparam int DIV_DW = 34;      // dividend / quotient register
    localparam int DIV_VW = 33;      // divisor
    localparam int DIV_CW = 6;       // step counter

    // Stream packing
    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 56;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEN = 1'b1;

    // Timing constants
    localparam logic [16:0]          TICKS_PER_SEC  = 17'd90000;
    localparam logic [PW-1:0]        DEFAULT_PERIOD = PW'(3600);
    localparam logic [PW-1:0]        MIN_PERIOD     = PW'(4);
    localparam logic signed [SW-1:0] BORDER_SLACK   = SW'(100);
    localparam logic signed [SW-1:0] MAX_AHEAD      = SW'(3 * 3600);

    // Divider step counts: full period division, and quarter-phase index
    localparam logic [DIV_CW-1:0] DIV_STEPS_PERIOD = DIV_CW'(PW);
    localparam logic [DIV_CW-1:0] DIV_STEPS_PHASE  = DIV_CW'(6);

    // Divider operand select
    localparam logic DIV_SEL_PERIOD = 1'b0;
    localparam logic DIV_SEL_PHASE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_SKIP    = 2'd0;
    localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJECT  = 2'd2;
    localparam logic [STAT_W-1:0] ST_ACCEPT  = 2'd3;

    // Frame counter actions
    localparam logic [ACT_W-1:0] ACT_LEAVE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ZERO  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TWO   = 2'd2;

    // Signed offset limits
    localparam logic signed [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};
    localparam logic signed [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // latch input item, form 90000*num
        logic div_start;   // launch divider
        logic div_sel;     // divider operands
        logic period_ld;   // capture frame period
        logic eval1;       // ahead, waited, limits
        logic eval2;       // z, first rejection terms
        logic eval3;       // final rejection, border window
        logic upd_rej;     // rejected measurement update
        logic upd_acc;     // accepted: border nudge, clear retries
        logic upd_half;    // accepted: half-period field shift
        logic res_ld;      // load output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic skip;        // trick mode or sync timeout
        logic reject;      // measurement rejected
        logic div_busy;
        logic div_done;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hdl/fpsc_div.sv =====
// ---------------------------------------------------------------------------
// fpsc_div
// Restoring divider, one quotient bit per cycle. The caller gives the number
// of steps; the quotient must fit in that many bits.
// ---------------------------------------------------------------------------
`default_nettype none

module fpsc_div
    import fpsc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_CW-1:0] i_steps,
    input  wire logic [DIV_DW-1:0] i_dividend,
    input  wire logic [DIV_VW-1:0] i_divisor,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [DIV_DW-1:0]      o_quot
);

    logic              r_busy;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_acc;
    logic [DIV_VW-1:0] r_rem;
    logic [DIV_VW-1:0] r_dvs;

    logic [DIV_VW:0]   w_trial;
    logic [DIV_VW:0]   w_diff;
    logic [DIV_CW-1:0] w_shift;
    logic              n_qbit;
    logic [DIV_VW-1:0] n_rem;

    // One trial subtraction per step
    always_comb begin
        w_trial = {r_rem, r_acc[DIV_DW-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        n_qbit  = (w_trial >= {1'b0, r_dvs});
        n_rem   = n_qbit ? w_diff[DIV_VW-1:0] : w_trial[DIV_VW-1:0];
        w_shift = DIV_CW'(DIV_DW) - i_steps;
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Align dividend bits to shift in; shift quotient bits in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend << w_shift;
            r_rem <= DIV_VW'(i_dividend >> i_steps);
            r_dvs <= i_divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= n_rem;
            r_acc <= {r_acc[DIV_DW-2:0], n_qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_acc;

endmodule

`default_nettype wire

// ===== hdl/fpsc_dp.sv =====
// ---------------------------------------------------------------------------
// fpsc_dp
// Datapath: configuration registers, item latch, frame period, measurement
// evaluation, saturating offset and retry state, result register.
// ---------------------------------------------------------------------------
`default_nettype none

module fpsc_dp
    import fpsc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_trick,
    input  wire logic                 i_sync,
    input  wire logic [TS_W-1:0]      i_pts,
    input  wire logic [TS_W-1:0]      i_before,
    input  wire logic [TS_W-1:0]      i_after,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    output logic [STAT_W-1:0]         o_status,
    output logic [ACT_W-1:0]          o_action,
    output logic                      o_adjusted,
    output logic signed [OFF_W-1:0]   o_offset,
    output logic [RTR_W-1:0]          o_retries
);

    // Configuration and persistent state
    logic [CFG_W-1:0]        r_num;
    logic [CFG_W-1:0]        r_den;
    logic signed [OFF_W-1:0] r_off;
    logic [RTR_W-1:0]        r_retry;

    // Item working registers
    logic                    r_trick;
    logic                    r_sync;
    logic [TS_W-1:0]         r_pts;
    logic [TS_W-1:0]         r_before;
    logic [TS_W-1:0]         r_after;
    logic [PW-1:0]           r_prod;
    logic [PW-1:0]           r_period;
    logic signed [SW-1:0]    r_ahead;
    logic signed [SW-1:0]    r_waited;
    logic signed [SW-1:0]    r_lim;
    logic signed [SW-1:0]    r_border;
    logic signed [SW-1:0]    r_z;
    logic signed [SW-1:0]    r_blo;
    logic signed [SW-1:0]    r_bhi;
    logic                    r_rej_a;
    logic                    r_rej;
    logic                    r_bord;
    logic                    r_adj;

    // Result register
    logic [STAT_W-1:0]       r_o_status;
    logic [ACT_W-1:0]        r_o_action;
    logic                    r_o_adj;
    logic signed [OFF_W-1:0] r_o_off;
    logic [RTR_W-1:0]        r_o_retry;

    logic [PW-1:0]           w_prod;
    logic [DIV_DW-1:0]       w_dvd;
    logic [DIV_VW-1:0]       w_dvs;
    logic [DIV_CW-1:0]       w_steps;
    logic                    w_div_busy;
    logic                    w_div_done;
    logic [DIV_DW-1:0]       w_quot;
    logic signed [SW-1:0]    w_period_s;
    logic signed [SW-1:0]    w_p8;
    logic signed [OFF_W-1:0] w_half;
    logic signed [OFF_W-1:0] w_eighth;
    logic signed [OFF_W-1:0] w_delta;
    logic signed [OFF_W:0]   w_sum;
    logic signed [OFF_W-1:0] n_off;
    logic                    w_off_en;
    logic [STAT_W-1:0]       w_status;
    logic [ACT_W-1:0]        w_action;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= '0;
            r_den <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NUM: r_num <= i_cfg_wdata;
                REG_DEN: r_den <= i_cfg_wdata;
            endcase
        end
    end

    assign w_prod = PW'(TICKS_PER_SEC) * PW'(r_num);

    // Shared divider operands: period from 90000*num/den, or phase z/(period/4)
    always_comb begin
        if (i_cmd.div_sel == DIV_SEL_PHASE) begin
            w_dvd   = r_z[DIV_DW-1:0];
            w_dvs   = {2'b00, r_period[PW-1:2]};
            w_steps = DIV_STEPS_PHASE;
        end else begin
            w_dvd   = {1'b0, r_prod};
            w_dvs   = {{(DIV_VW-CFG_W){1'b0}}, r_den};
            w_steps = DIV_STEPS_PERIOD;
        end
    end

    fpsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_steps    (w_steps),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_period_s = $signed({{(SW-PW){1'b0}}, r_period});
    assign w_p8       = w_period_s <<< 3;

    // Latch item, evaluate measurement in three short stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_trick  <= i_trick;
            r_sync   <= i_sync;
            r_pts    <= i_pts;
            r_before <= i_before;
            r_after  <= i_after;
            r_prod   <= w_prod;
        end
        if (i_cmd.period_ld) begin
            if (r_den == '0) begin
                r_period <= DEFAULT_PERIOD;
            end else if (w_quot[PW-1:0] < MIN_PERIOD) begin
                r_period <= MIN_PERIOD;
            end else begin
                r_period <= w_quot[PW-1:0];
            end
        end
        if (i_cmd.eval1) begin
            r_ahead  <= $signed({{(SW-TS_W){1'b0}}, r_pts})
                      - $signed({{(SW-TS_W){1'b0}}, r_after});
            r_waited <= $signed({{(SW-TS_W){1'b0}}, r_after})
                      - $signed({{(SW-TS_W){1'b0}}, r_before});
            r_lim    <= w_period_s + BORDER_SLACK;
            r_border <= w_period_s + (w_period_s >>> 1);
        end
        if (i_cmd.eval2) begin
            r_z     <= r_ahead + w_period_s;
            r_rej_a <= (r_waited > r_lim) || r_ahead[SW-1] || (r_ahead > MAX_AHEAD);
            r_blo   <= r_border - BORDER_SLACK;
            r_bhi   <= r_border + BORDER_SLACK;
        end
        if (i_cmd.eval3) begin
            r_rej  <= r_rej_a || r_z[SW-1] || (r_z > w_p8);
            r_bord <= (r_z > r_blo) && (r_z < r_bhi);
        end
    end

    // Offset change: plus half a period, or minus an eighth, saturated
    always_comb begin
        w_half   = $signed({{(OFF_W-PW+1){1'b0}}, r_period[PW-1:1]});
        w_eighth = $signed({{(OFF_W-PW+3){1'b0}}, r_period[PW-1:3]});
        w_delta  = i_cmd.upd_half ? w_half : -w_eighth;
        w_sum    = {r_off[OFF_W-1], r_off} + {w_delta[OFF_W-1], w_delta};
        if (w_sum[OFF_W] != w_sum[OFF_W-1]) begin
            n_off = w_sum[OFF_W] ? OFF_MIN : OFF_MAX;
        end else begin
            n_off = w_sum[OFF_W-1:0];
        end
        w_off_en = (i_cmd.upd_rej && r_z[SW-1])
                || (i_cmd.upd_acc && r_bord)
                || (i_cmd.upd_half && !w_quot[1]);
    end

    // Persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_retry <= '0;
        end else begin
            if (w_off_en) begin
                r_off <= n_off;
            end
            if (i_cmd.upd_rej && (r_retry != {RTR_W{1'b1}})) begin
                r_retry <= r_retry + 1'b1;
            end else if (i_cmd.upd_acc) begin
                r_retry <= '0;
            end
        end
    end

    // Field shift flag for the current item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_adj <= 1'b0;
        end else if (i_cmd.upd_half) begin
            r_adj <= !w_quot[1];
        end
    end

    // Result classification
    always_comb begin
        if (r_trick) begin
            w_status = ST_SKIP;
        end else if (!r_sync) begin
            w_status = ST_TIMEOUT;
        end else if (r_rej) begin
            w_status = ST_REJECT;
        end else begin
            w_status = ST_ACCEPT;
        end
        case (w_status)
            ST_TIMEOUT: w_action = ACT_ZERO;
            ST_REJECT:  w_action = ACT_TWO;
            default:    w_action = ACT_LEAVE;
        endcase
    end

    // Snapshot the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ld) begin
            r_o_status <= w_status;
            r_o_action <= w_action;
            r_o_adj    <= r_adj;
            r_o_off    <= r_off;
            r_o_retry  <= r_retry;
        end
    end

    assign o_stat.skip     = r_trick || !r_sync;
    assign o_stat.reject   = r_rej;
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.div_done = w_div_done;

    assign o_status   = r_o_status;
    assign o_action   = r_o_action;
    assign o_adjusted = r_o_adj;
    assign o_offset   = r_o_off;
    assign o_retries  = r_o_retry;

endmodule

`default_nettype wire

// ===== hdl/fpsc_ctrl.sv =====
// ---------------------------------------------------------------------------
// fpsc_ctrl
// Sequencer: walks one item through period division, evaluation, state
// update and, for accepted measurements, phase division; owns the output valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module fpsc_ctrl
    import fpsc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire logic     i_out_ready,
    output logic          o_out_valid,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_PWAIT = 4'd2;
    localparam logic [3:0] S_EVAL1 = 4'd3;
    localparam logic [3:0] S_EVAL2 = 4'd4;
    localparam logic [3:0] S_EVAL3 = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_MWAIT = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.skip) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_SEL_PERIOD;
                    n_state         = S_PWAIT;
                end
            end
            S_PWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.period_ld = 1'b1;
                    n_state         = S_EVAL1;
                end
            end
            S_EVAL1: begin
                o_cmd.eval1 = 1'b1;
                n_state     = S_EVAL2;
            end
            S_EVAL2: begin
                o_cmd.eval2 = 1'b1;
                n_state     = S_EVAL3;
            end
            S_EVAL3: begin
                o_cmd.eval3 = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                if (i_stat.reject) begin
                    o_cmd.upd_rej = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.upd_acc   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_SEL_PHASE;
                    n_state         = S_MWAIT;
                end
            end
            S_MWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.upd_half = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold result valid until taken
    always_comb begin
        if (o_cmd.res_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hdl/field_parity_sync_corrector_core.sv =====
// ---------------------------------------------------------------------------
// field_parity_sync_corrector_core
// Keeps a presentation offset and retry count from per-frame timestamp and
// clock samples taken around a field-sync wait.
// Input stream (s_axis): one item per frame; tuser flags, tdata timestamps.
// Output stream (m_axis): exactly one result item per input item, in order.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_wdata write frame rate num (0) and
// den (1); write only while no item is in flight.
// After accept, trick-mode and sync-timeout items go straight to the output;
// measurements pass through the bit-serial period division (90000*num/den),
// evaluation and the update, then on acceptance the quarter-phase
// division on the same divider, plus handshake.
// One item is worked on at a time: a new item is accepted only once the
// last one's result has been loaded into the output register.
// Reset (synchronous, active low) clears offset, retry count, frame rate
// registers and both stream sides.
// A stalled receiver holds the finished result in the output register;
// the next item is still accepted and worked on, and waits for the slot.
// ---------------------------------------------------------------------------
`default_nettype none

`include "field_parity_sync_corrector_core_assert.svh"

module field_parity_sync_corrector_core
    import fpsc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    // Input items
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [32:0] present_time, [65:33] clock_before, [98:66] clock_after
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] trick_mode, [1] sync_ok
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    // Result items
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [1:0] frame_counter_action, [2] field_adjusted, [42:3] new_offset,
    // [50:43] retries_now
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // [1:0] status
    output logic [STAT_W-1:0]           m_axis_tuser
);

    t_dp_cmd                 w_cmd;
    t_dp_stat                w_stat;
    logic [ACT_W-1:0]        w_action;
    logic                    w_adjusted;
    logic signed [OFF_W-1:0] w_offset;
    logic [RTR_W-1:0]        w_retries;

    fpsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    fpsc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_trick     (s_axis_tuser[0]),
        .i_sync      (s_axis_tuser[1]),
        .i_pts       (s_axis_tdata[TS_W-1:0]),
        .i_before    (s_axis_tdata[2*TS_W-1:TS_W]),
        .i_after     (s_axis_tdata[3*TS_W-1:2*TS_W]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_status    (m_axis_tuser),
        .o_action    (w_action),
        .o_adjusted  (w_adjusted),
        .o_offset    (w_offset),
        .o_retries   (w_retries)
    );

    // Pack result fields, zero fill to whole bytes
    assign m_axis_tdata = {
        {(OUT_TDATA_W-ACT_W-1-OFF_W-RTR_W){1'b0}},
        w_retries, w_offset, w_adjusted, w_action
    };

    // Input side closes for the item being worked on
    `FPSC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // Result register is never overwritten while still held
    `FPSC_ASSERT_IMP(a_result_slot_free, i_clk, i_rst_n, w_cmd.res_ld, !m_axis_tvalid || m_axis_tready)
    // Divider is launched only when idle
    `FPSC_ASSERT_IMP(a_div_idle_start, i_clk, i_rst_n, w_cmd.div_start, !w_stat.div_busy)
    // Skipped items never touch offset or retry state
    `FPSC_ASSERT_IMP(a_skip_no_update, i_clk, i_rst_n, w_cmd.upd_rej || w_cmd.upd_acc || w_cmd.upd_half, !w_stat.skip)

endmodule

`default_nettype wire
